/* hdl/sdseq_pkg.sv */
// Package for the SD card bring-up and block sequencer: codes, types and constants.
package sdseq_pkg;

    localparam int SECTOR_BYTES_DEFAULT = 512;

    localparam int TRIES_W = 10;
    localparam int BUS_W   = 2;
    localparam int RCA_W   = 16;
    localparam int WORD_W  = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [TRIES_W-1:0] OP_COND_TRIES_RESET = 10'd1000;
    localparam logic [BUS_W-1:0]   BUS_WIDTH_RESET     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_OP_COND_MAX_TRIES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUS_WIDTH_CODE    = 1'd1;

    localparam logic [11:0] CMD8_CHECK_PATTERN = 12'h1AA;
    localparam logic [WORD_W-1:0] CMD8_ARG     = 32'h0000_01AA;
    localparam logic [WORD_W-1:0] ACMD41_ARG   = 32'h40FF_8000;
    localparam int OCR_BUSY_BIT = 31;
    localparam int OCR_CCS_BIT  = 30;

    localparam logic [5:0] CMD_GO_IDLE     = 6'd0;
    localparam logic [5:0] CMD_ALL_SEND_CID = 6'd2;
    localparam logic [5:0] CMD_SEND_RCA    = 6'd3;
    localparam logic [5:0] CMD_SET_BUS_W   = 6'd6;
    localparam logic [5:0] CMD_SELECT      = 6'd7;
    localparam logic [5:0] CMD_SEND_IF     = 6'd8;
    localparam logic [5:0] CMD_SEND_CSD    = 6'd9;
    localparam logic [5:0] CMD_READ_BLOCK  = 6'd17;
    localparam logic [5:0] CMD_WRITE_BLOCK = 6'd24;
    localparam logic [5:0] CMD_OP_COND     = 6'd41;
    localparam logic [5:0] CMD_APP         = 6'd55;

    typedef enum logic [1:0] {
        FUNC_START = 2'd0,
        FUNC_DONE  = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_WRITE = 2'd3
    } func_t;

    localparam logic [1:0] CST_OK       = 2'd0;
    localparam logic [1:0] CST_TIMEOUT  = 2'd1;
    localparam logic [1:0] CST_PROTOCOL = 2'd2;

    localparam logic [2:0] FST_OK        = 3'd0;
    localparam logic [2:0] FST_TIMEOUT   = 3'd1;
    localparam logic [2:0] FST_PROTOCOL  = 3'd2;
    localparam logic [2:0] FST_NOT_READY = 3'd4;

    localparam logic [1:0] RESP_NONE  = 2'd0;
    localparam logic [1:0] RESP_SHORT = 2'd1;
    localparam logic [1:0] RESP_LONG  = 2'd2;

    localparam logic KIND_CMD    = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [11:0] {
        PH_IDLE   = 12'b0000_0000_0001,
        PH_CMD0   = 12'b0000_0000_0010,
        PH_CMD8   = 12'b0000_0000_0100,
        PH_OC55   = 12'b0000_0000_1000,
        PH_ACMD41 = 12'b0000_0001_0000,
        PH_CMD2   = 12'b0000_0010_0000,
        PH_CMD3   = 12'b0000_0100_0000,
        PH_CMD9   = 12'b0000_1000_0000,
        PH_CMD7   = 12'b0001_0000_0000,
        PH_BW55   = 12'b0010_0000_0000,
        PH_ACMD6  = 12'b0100_0000_0000,
        PH_XFER   = 12'b1000_0000_0000
    } phase_t;

    typedef struct packed {
        phase_t             phase;
        logic [RCA_W-1:0]   card_address;
        logic               block_addressing;
        logic [TRIES_W-1:0] tries_used;
        logic               initialized;
    } seq_state_t;

    typedef struct packed {
        logic [TRIES_W-1:0] op_cond_max_tries;
        logic [BUS_W-1:0]   bus_width_code;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        func;
        logic [1:0]        cmd_status;
        logic [WORD_W-1:0] response_word;
        logic [WORD_W-1:0] block_address;
    } req_t;

    typedef struct packed {
        logic              result_kind;
        logic [5:0]        cmd_num;
        logic [WORD_W-1:0] cmd_argument;
        logic [1:0]        response_kind;
        logic              verify_crc;
        logic              send_init_seq;
        logic              data_transfer;
        logic              write_direction;
        logic [2:0]        final_status;
        logic              card_ready;
        logic              high_capacity;
    } res_t;

endpackage

/* hdl/sdseq_req_if.sv */
// Request channel into the sequencer: function code, completion status and addresses.
interface sdseq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [1:0]  cmd_status;
    logic [31:0] response_word;
    logic [31:0] block_address;

    modport source (output valid, output func, output cmd_status, output response_word,
                    output block_address, input ready);
    modport sink (input valid, input func, input cmd_status, input response_word,
                  input block_address, output ready);
endinterface

/* hdl/sdseq_res_if.sv */
// Result channel out of the sequencer: next command or final status.
interface sdseq_res_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [5:0]  cmd_num;
    logic [31:0] cmd_argument;
    logic [1:0]  response_kind;
    logic        verify_crc;
    logic        send_init_seq;
    logic        data_transfer;
    logic        write_direction;
    logic [2:0]  final_status;
    logic        card_ready;
    logic        high_capacity;

    modport source (output valid, output result_kind, output cmd_num, output cmd_argument,
                    output response_kind, output verify_crc, output send_init_seq,
                    output data_transfer, output write_direction, output final_status,
                    output card_ready, output high_capacity, input ready);
    modport sink (input valid, input result_kind, input cmd_num, input cmd_argument,
                  input response_kind, input verify_crc, input send_init_seq,
                  input data_transfer, input write_direction, input final_status,
                  input card_ready, input high_capacity, output ready);
endinterface

/* hdl/sdseq_cfg_if.sv */
// Configuration write channel: register index and write data.
interface sdseq_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [9:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* hdl/sdseq_cfg_regs.sv */
// Configuration registers: ACMD41 try limit and ACMD6 bus width code.
module sdseq_cfg_regs
    import sdseq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sdseq_cfg_if.sink   cfg,
    output cfg_t        cfg_out
);

    cfg_t cfg_reg;

    assign cfg.ready = 1'b1;
    assign cfg_out   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.op_cond_max_tries <= OP_COND_TRIES_RESET;
            cfg_reg.bus_width_code    <= BUS_WIDTH_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_OP_COND_MAX_TRIES: cfg_reg.op_cond_max_tries <= cfg.data;
                CFG_BUS_WIDTH_CODE:    cfg_reg.bus_width_code    <= cfg.data[BUS_W-1:0];
                default:               cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

/* hdl/sdseq_step.sv */
// Next-state and result logic for one request of the sequencer.
module sdseq_step
    import sdseq_pkg::*;
#(
    parameter int SECTOR_BYTES = SECTOR_BYTES_DEFAULT
)
(
    input  seq_state_t state,
    input  cfg_t       cfg,
    input  req_t       item,
    output seq_state_t state_next,
    output res_t       result
);

    function automatic res_t put_status(input logic [2:0] st);
        res_t r;
        r = '0;
        r.result_kind  = KIND_STATUS;
        r.final_status = st;
        return r;
    endfunction

    function automatic res_t put_cmd(input logic [5:0] idx, input logic [WORD_W-1:0] arg,
                                     input logic [1:0] rk, input logic crc,
                                     input logic init, input logic data, input logic wr);
        res_t r;
        r = '0;
        r.result_kind     = KIND_CMD;
        r.cmd_num         = idx;
        r.cmd_argument    = arg;
        r.response_kind   = rk;
        r.verify_crc      = (rk != RESP_NONE) ? crc : 1'b0;
        r.send_init_seq   = init;
        r.data_transfer   = data;
        r.write_direction = wr;
        return r;
    endfunction

    logic                 ok;
    logic [TRIES_W:0]     tries_inc;
    logic                 tries_out;
    logic [WORD_W-1:0]    rca_now;
    logic [WORD_W-1:0]    rca_new;
    logic [WORD_W-1:0]    byte_addr;
    logic [WORD_W-1:0]    xfer_arg;
    logic                 op_cond_fail;
    res_t                 res_core;

    assign ok        = (item.cmd_status == CST_OK);
    assign tries_inc = {1'b0, state.tries_used} + 1'b1;
    assign tries_out = (tries_inc >= {1'b0, cfg.op_cond_max_tries});
    assign rca_now   = {state.card_address, {(WORD_W - RCA_W){1'b0}}};
    assign rca_new   = {item.response_word[WORD_W-1 -: RCA_W], {(WORD_W - RCA_W){1'b0}}};
    assign byte_addr = WORD_W'(item.block_address * WORD_W'(SECTOR_BYTES));
    assign xfer_arg  = state.block_addressing ? item.block_address : byte_addr;

    always_comb
    begin
        state_next   = state;
        res_core     = put_status(FST_NOT_READY);
        op_cond_fail = 1'b0;

        case (func_t'(item.func))
            FUNC_START:
            begin
                state_next       = '0;
                state_next.phase = PH_CMD0;
                res_core = put_cmd(CMD_GO_IDLE, '0, RESP_NONE, 1'b0, 1'b1, 1'b0, 1'b0);
            end
            FUNC_DONE:
            begin
                case (state.phase)
                    PH_CMD0:
                        if (!ok)
                        begin
                            state_next.phase = PH_IDLE;
                            res_core = put_status({1'b0, item.cmd_status});
                        end
                        else
                        begin
                            state_next.phase = PH_CMD8;
                            res_core = put_cmd(CMD_SEND_IF, CMD8_ARG, RESP_SHORT,
                                               1'b1, 1'b0, 1'b0, 1'b0);
                        end
                    PH_CMD8:
                        if (!ok || item.response_word[11:0] != CMD8_CHECK_PATTERN)
                        begin
                            state_next.phase = PH_IDLE;
                            res_core = put_status(FST_PROTOCOL);
                        end
                        else
                        begin
                            state_next.tries_used = '0;
                            state_next.phase      = PH_OC55;
                            res_core = put_cmd(CMD_APP, rca_now, RESP_SHORT,
                                               1'b1, 1'b0, 1'b0, 1'b0);
                        end
                    PH_OC55:
                        if (!ok)
                        begin
                            op_cond_fail = 1'b1;
                        end
                        else
                        begin
                            state_next.phase = PH_ACMD41;
                            res_core = put_cmd(CMD_OP_COND, ACMD41_ARG, RESP_SHORT,
                                               1'b0, 1'b0, 1'b0, 1'b0);
                        end
                    PH_ACMD41:
                        if (!ok || !item.response_word[OCR_BUSY_BIT])
                        begin
                            op_cond_fail = 1'b1;
                        end
                        else
                        begin
                            state_next.block_addressing = item.response_word[OCR_CCS_BIT];
                            state_next.phase = PH_CMD2;
                            res_core = put_cmd(CMD_ALL_SEND_CID, '0, RESP_LONG,
                                               1'b1, 1'b0, 1'b0, 1'b0);
                        end
                    PH_CMD2:
                        if (!ok)
                        begin
                            state_next.phase = PH_IDLE;
                            res_core = put_status({1'b0, item.cmd_status});
                        end
                        else
                        begin
                            state_next.phase = PH_CMD3;
                            res_core = put_cmd(CMD_SEND_RCA, '0, RESP_SHORT,
                                               1'b1, 1'b0, 1'b0, 1'b0);
                        end
                    PH_CMD3:
                        if (!ok)
                        begin
                            state_next.phase = PH_IDLE;
                            res_core = put_status({1'b0, item.cmd_status});
                        end
                        else
                        begin
                            state_next.card_address = item.response_word[WORD_W-1 -: RCA_W];
                            state_next.phase = PH_CMD9;
                            res_core = put_cmd(CMD_SEND_CSD, rca_new, RESP_LONG,
                                               1'b1, 1'b0, 1'b0, 1'b0);
                        end
                    PH_CMD9:
                    begin
                        // The CSD contents and status are not used; selection always follows.
                        state_next.phase = PH_CMD7;
                        res_core = put_cmd(CMD_SELECT, rca_now, RESP_SHORT,
                                           1'b1, 1'b0, 1'b0, 1'b0);
                    end
                    PH_CMD7:
                        if (!ok)
                        begin
                            state_next.phase = PH_IDLE;
                            res_core = put_status({1'b0, item.cmd_status});
                        end
                        else
                        begin
                            state_next.phase = PH_BW55;
                            res_core = put_cmd(CMD_APP, rca_now, RESP_SHORT,
                                               1'b1, 1'b0, 1'b0, 1'b0);
                        end
                    PH_BW55:
                        if (!ok)
                        begin
                            state_next.phase = PH_IDLE;
                            res_core = put_status({1'b0, item.cmd_status});
                        end
                        else
                        begin
                            state_next.phase = PH_ACMD6;
                            res_core = put_cmd(CMD_SET_BUS_W,
                                               {{(WORD_W - BUS_W){1'b0}}, cfg.bus_width_code},
                                               RESP_SHORT, 1'b1, 1'b0, 1'b0, 1'b0);
                        end
                    PH_ACMD6:
                    begin
                        state_next.phase = PH_IDLE;
                        if (ok)
                        begin
                            state_next.initialized = 1'b1;
                        end
                        res_core = put_status({1'b0, item.cmd_status});
                    end
                    PH_XFER:
                    begin
                        state_next.phase = PH_IDLE;
                        res_core = put_status({1'b0, item.cmd_status});
                    end
                    default:
                        res_core = put_status(FST_NOT_READY);
                endcase
            end
            default:
            begin
                if (state.initialized && state.phase == PH_IDLE)
                begin
                    state_next.phase = PH_XFER;
                    res_core = put_cmd((item.func == FUNC_WRITE) ? CMD_WRITE_BLOCK
                                                                 : CMD_READ_BLOCK,
                                       xfer_arg, RESP_SHORT, 1'b1, 1'b0, 1'b1,
                                       (item.func == FUNC_WRITE));
                end
            end
        endcase

        // A failed op-cond attempt either retries CMD55 or gives up with timeout.
        if (op_cond_fail)
        begin
            if (tries_out)
            begin
                state_next.phase = PH_IDLE;
                res_core = put_status(FST_TIMEOUT);
            end
            else
            begin
                state_next.tries_used = tries_inc[TRIES_W-1:0];
                state_next.phase      = PH_OC55;
                res_core = put_cmd(CMD_APP, rca_now, RESP_SHORT, 1'b1, 1'b0, 1'b0, 1'b0);
            end
        end
    end

    always_comb
    begin
        result               = res_core;
        result.card_ready    = state_next.initialized;
        result.high_capacity = state_next.block_addressing;
    end

endmodule

/* hdl/sd_card_init_and_block_sequencer_top.sv */
// Top level of the SD card bring-up and block sequencer.
//
//  channel  | modport | payload                                         | accepted when
//  ---------+---------+-------------------------------------------------+----------------------
//  req      | sink    | func, cmd_status, response_word, block_address  | req.valid & req.ready
//  res      | source  | command fields or final status, card flags      | res.valid & res.ready
//  cfg      | sink    | index, data (ACMD41 try limit, bus width code)  | cfg.valid (ready high)
//
// A request is captured in an input register and stepped through the sequencer state in the
// following cycle unless the result register is stalled; the step fills the result register,
// and one request per cycle passes while results are taken; the phase register update sets the rate.
// While the result register is stalled, one more request waits in the input register.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and not initialized,
// with the try limit at 1000 and the bus width code at 2.
module sd_card_init_and_block_sequencer_top
    import sdseq_pkg::*;
#(
    parameter int SECTOR_BYTES = SECTOR_BYTES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    sdseq_req_if.sink   req,
    sdseq_res_if.source res,
    sdseq_cfg_if.sink   cfg
);

    cfg_t       cfg_cur;
    seq_state_t state_reg;
    seq_state_t state_next;
    req_t       in_item_reg;
    logic       in_valid_reg;
    res_t       out_res_reg;
    res_t       out_res_next;
    logic       out_valid_reg;
    logic       advance;

    sdseq_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_cur)
    );

    sdseq_step #(
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_step (
        .state      (state_reg),
        .cfg        (cfg_cur),
        .item       (in_item_reg),
        .state_next (state_next),
        .result     (out_res_next)
    );

    assign advance   = in_valid_reg && (!out_valid_reg || res.ready);
    assign req.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            state_reg        <= '{PH_IDLE, {RCA_W{1'b0}}, 1'b0, {TRIES_W{1'b0}}, 1'b0};
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_item_reg.func          <= req.func;
            in_item_reg.cmd_status    <= req.cmd_status;
            in_item_reg.response_word <= req.response_word;
            in_item_reg.block_address <= req.block_address;
        end
        if (advance)
        begin
            out_res_reg <= out_res_next;
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.result_kind     = out_res_reg.result_kind;
    assign res.cmd_num         = out_res_reg.cmd_num;
    assign res.cmd_argument    = out_res_reg.cmd_argument;
    assign res.response_kind   = out_res_reg.response_kind;
    assign res.verify_crc      = out_res_reg.verify_crc;
    assign res.send_init_seq   = out_res_reg.send_init_seq;
    assign res.data_transfer   = out_res_reg.data_transfer;
    assign res.write_direction = out_res_reg.write_direction;
    assign res.final_status    = out_res_reg.final_status;
    assign res.card_ready      = out_res_reg.card_ready;
    assign res.high_capacity   = out_res_reg.high_capacity;

    // A ready card has no bring-up command outstanding.
    a_ready_phase: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.initialized |-> (state_reg.phase == PH_IDLE || state_reg.phase == PH_XFER))
        else $error("initialized card with bring-up phase outstanding");

    // A stepped request always lands in the result register.
    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("stepped request did not produce a result");

    // With both registers full and the sink stalled, no new request may enter.
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !res.ready) |-> !req.ready)
        else $error("request accepted while pipeline is full");

    // A command result never carries a final status.
    a_cmd_no_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.result_kind == KIND_CMD) |->
            (out_res_reg.final_status == FST_OK))
        else $error("command result with nonzero final status");

endmodule

/* test/sdseq_command_checker.sv */
`timescale 1ns / 1ps
// Checker for the SD sequencer: watches all three channels, predicts each answer and compares.
module sdseq_command_checker
    import sdseq_pkg::*;
#(
    parameter int SECTOR_BYTES = SECTOR_BYTES_DEFAULT
)
(
    input  logic  clk,
    input  logic  rst_n,
    sdseq_req_if  req,
    sdseq_res_if  res,
    sdseq_cfg_if  cfg,
    output int    fail_count,
    output int    pending,
    output int    compared
);

    phase_t             seq_phase;
    logic [RCA_W-1:0]   rca;
    logic               hc;
    logic [TRIES_W-1:0] tries;
    logic               card_up;
    logic [TRIES_W-1:0] max_tries;
    logic [BUS_W-1:0]   bus_code;

    res_t expected_cmds[$];

    initial begin
        fail_count = 0;
        pending    = 0;
        compared   = 0;
    end

    function automatic res_t status_result(logic [2:0] st);
        res_t r;
        r = '0;
        r.result_kind   = KIND_STATUS;
        r.final_status  = st;
        r.card_ready    = card_up;
        r.high_capacity = hc;
        return r;
    endfunction

    function automatic res_t command_result(logic [5:0] idx, logic [31:0] arg, logic [1:0] rk,
                                            logic crc, logic init, logic data, logic wr);
        res_t r;
        r = '0;
        r.result_kind     = KIND_CMD;
        r.cmd_num         = idx;
        r.cmd_argument    = arg;
        r.response_kind   = rk;
        r.verify_crc      = (rk != RESP_NONE) && crc;
        r.send_init_seq   = init;
        r.data_transfer   = data;
        r.write_direction = wr;
        r.card_ready      = card_up;
        r.high_capacity   = hc;
        return r;
    endfunction

    // A failed CMD55 or ACMD41 counts one attempt; the limit ends bring-up with a timeout.
    task automatic op_cond_miss(output res_t nxt);
        if ({1'b0, tries} + 11'd1 >= {1'b0, max_tries})
        begin
            seq_phase = PH_IDLE;
            nxt = status_result(FST_TIMEOUT);
        end
        else
        begin
            tries = tries + 1'b1;
            seq_phase = PH_OC55;
            nxt = command_result(CMD_APP, {rca, 16'h0}, RESP_SHORT, 1'b1, 1'b0, 1'b0, 1'b0);
        end
    endtask

    task automatic finish_command(logic [1:0] st, logic [31:0] resp, output res_t nxt);
        logic ok;
        ok = (st == CST_OK);
        case (seq_phase)
            PH_CMD0:
                if (!ok)
                begin
                    seq_phase = PH_IDLE;
                    nxt = status_result({1'b0, st});
                end
                else
                begin
                    seq_phase = PH_CMD8;
                    nxt = command_result(CMD_SEND_IF, CMD8_ARG, RESP_SHORT, 1'b1, 1'b0, 1'b0,
                                         1'b0);
                end
            PH_CMD8:
                if (!ok || resp[11:0] != CMD8_CHECK_PATTERN)
                begin
                    seq_phase = PH_IDLE;
                    nxt = status_result(FST_PROTOCOL);
                end
                else
                begin
                    tries = '0;
                    seq_phase = PH_OC55;
                    nxt = command_result(CMD_APP, {rca, 16'h0}, RESP_SHORT, 1'b1, 1'b0, 1'b0,
                                         1'b0);
                end
            PH_OC55:
                if (!ok)
                    op_cond_miss(nxt);
                else
                begin
                    seq_phase = PH_ACMD41;
                    nxt = command_result(CMD_OP_COND, ACMD41_ARG, RESP_SHORT, 1'b0, 1'b0, 1'b0,
                                         1'b0);
                end
            PH_ACMD41:
                if (!ok || !resp[OCR_BUSY_BIT])
                    op_cond_miss(nxt);
                else
                begin
                    hc = resp[OCR_CCS_BIT];
                    seq_phase = PH_CMD2;
                    nxt = command_result(CMD_ALL_SEND_CID, '0, RESP_LONG, 1'b1, 1'b0, 1'b0, 1'b0);
                end
            PH_CMD2:
                if (!ok)
                begin
                    seq_phase = PH_IDLE;
                    nxt = status_result({1'b0, st});
                end
                else
                begin
                    seq_phase = PH_CMD3;
                    nxt = command_result(CMD_SEND_RCA, '0, RESP_SHORT, 1'b1, 1'b0, 1'b0, 1'b0);
                end
            PH_CMD3:
                if (!ok)
                begin
                    seq_phase = PH_IDLE;
                    nxt = status_result({1'b0, st});
                end
                else
                begin
                    rca = resp[31:16];
                    seq_phase = PH_CMD9;
                    nxt = command_result(CMD_SEND_CSD, {rca, 16'h0}, RESP_LONG, 1'b1, 1'b0, 1'b0,
                                         1'b0);
                end
            PH_CMD9:
            begin
                // The CSD read outcome does not matter; selection always follows.
                seq_phase = PH_CMD7;
                nxt = command_result(CMD_SELECT, {rca, 16'h0}, RESP_SHORT, 1'b1, 1'b0, 1'b0,
                                     1'b0);
            end
            PH_CMD7:
                if (!ok)
                begin
                    seq_phase = PH_IDLE;
                    nxt = status_result({1'b0, st});
                end
                else
                begin
                    seq_phase = PH_BW55;
                    nxt = command_result(CMD_APP, {rca, 16'h0}, RESP_SHORT, 1'b1, 1'b0, 1'b0,
                                         1'b0);
                end
            PH_BW55:
                if (!ok)
                begin
                    seq_phase = PH_IDLE;
                    nxt = status_result({1'b0, st});
                end
                else
                begin
                    seq_phase = PH_ACMD6;
                    nxt = command_result(CMD_SET_BUS_W, {30'b0, bus_code}, RESP_SHORT, 1'b1,
                                         1'b0, 1'b0, 1'b0);
                end
            PH_ACMD6:
            begin
                seq_phase = PH_IDLE;
                if (ok)
                    card_up = 1'b1;
                nxt = status_result({1'b0, st});
            end
            PH_XFER:
            begin
                seq_phase = PH_IDLE;
                nxt = status_result({1'b0, st});
            end
            default:
                nxt = status_result(FST_NOT_READY);
        endcase
    endtask

    task automatic advance_sequencer(req_t item, output res_t nxt);
        logic        wr;
        logic [31:0] arg;
        wr = (item.func == FUNC_WRITE);
        case (item.func)
            FUNC_START:
            begin
                card_up   = 1'b0;
                hc        = 1'b0;
                rca       = '0;
                tries     = '0;
                seq_phase = PH_CMD0;
                nxt = command_result(CMD_GO_IDLE, '0, RESP_NONE, 1'b0, 1'b1, 1'b0, 1'b0);
            end
            FUNC_DONE:
                finish_command(item.cmd_status, item.response_word, nxt);
            default:
                if (!card_up || seq_phase != PH_IDLE)
                    nxt = status_result(FST_NOT_READY);
                else
                begin
                    // Standard capacity cards take a byte address, cut to 32 bits.
                    arg = hc ? item.block_address : item.block_address * SECTOR_BYTES;
                    seq_phase = PH_XFER;
                    nxt = command_result(wr ? CMD_WRITE_BLOCK : CMD_READ_BLOCK, arg, RESP_SHORT,
                                         1'b1, 1'b0, 1'b1, wr);
                end
        endcase
    endtask

    task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
            fail_count = fail_count + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        res_t got;
        res_t want;
        res_t nxt;
        req_t item;
        if (!rst_n)
        begin
            seq_phase = PH_IDLE;
            rca       = '0;
            hc        = 1'b0;
            tries     = '0;
            card_up   = 1'b0;
            max_tries = OP_COND_TRIES_RESET;
            bus_code  = BUS_WIDTH_RESET;
            expected_cmds.delete();
            pending   = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_OP_COND_MAX_TRIES)
                    max_tries = cfg.data;
                else
                    bus_code = cfg.data[BUS_W-1:0];
            end
            if (res.valid && res.ready)
            begin
                got.result_kind     = res.result_kind;
                got.cmd_num         = res.cmd_num;
                got.cmd_argument    = res.cmd_argument;
                got.response_kind   = res.response_kind;
                got.verify_crc      = res.verify_crc;
                got.send_init_seq   = res.send_init_seq;
                got.data_transfer   = res.data_transfer;
                got.write_direction = res.write_direction;
                got.final_status    = res.final_status;
                got.card_ready      = res.card_ready;
                got.high_capacity   = res.high_capacity;
                if (expected_cmds.size() == 0)
                begin
                    $display("%0t ns: result expected none, got kind %0d cmd %0d status %0d",
                             $time, got.result_kind, got.cmd_num, got.final_status);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    compare_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
                    compare_field("cmd_num", 32'(want.cmd_num), 32'(got.cmd_num));
                    compare_field("cmd_argument", want.cmd_argument, got.cmd_argument);
                    compare_field("response_kind", 32'(want.response_kind),
                                  32'(got.response_kind));
                    compare_field("verify_crc", 32'(want.verify_crc), 32'(got.verify_crc));
                    compare_field("send_init_seq", 32'(want.send_init_seq),
                                  32'(got.send_init_seq));
                    compare_field("data_transfer", 32'(want.data_transfer),
                                  32'(got.data_transfer));
                    compare_field("write_direction", 32'(want.write_direction),
                                  32'(got.write_direction));
                    compare_field("final_status", 32'(want.final_status),
                                  32'(got.final_status));
                    compare_field("card_ready", 32'(want.card_ready), 32'(got.card_ready));
                    compare_field("high_capacity", 32'(want.high_capacity),
                                  32'(got.high_capacity));
                    compared = compared + 1;
                end
            end
            if (req.valid && req.ready)
            begin
                item.func          = req.func;
                item.cmd_status    = req.cmd_status;
                item.response_word = req.response_word;
                item.block_address = req.block_address;
                advance_sequencer(item, nxt);
                expected_cmds.push_back(nxt);
            end
            pending = expected_cmds.size();
        end
    end

endmodule

/* test/sd_card_init_and_block_sequencer_top_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the SD sequencer: clock, reset, request and result traffic, and verdict.
module sd_card_init_and_block_sequencer_top_tb;
    import sdseq_pkg::*;

    localparam logic [1:0] CST_DATA_IO = 2'd3;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    sdseq_req_if req();
    sdseq_res_if res();
    sdseq_cfg_if cfg();

    int fail_count;
    int pending;
    int compared;

    int sent       = 0;
    int settings   = 0;
    int bring_ups  = 0;
    int transfers  = 0;
    bit sender_burst = 1'b0;
    bit card_up      = 1'b0;
    logic [TRIES_W-1:0] tries_limit = OP_COND_TRIES_RESET;

    sd_card_init_and_block_sequencer_top #(.SECTOR_BYTES(SECTOR_BYTES_DEFAULT)) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .res   (res),
        .cfg   (cfg)
    );

    sdseq_command_checker #(.SECTOR_BYTES(SECTOR_BYTES_DEFAULT)) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .res        (res),
        .cfg        (cfg),
        .fail_count (fail_count),
        .pending    (pending),
        .compared   (compared)
    );

    always #2 clk = ~clk;

    function automatic bit chance(int n);
        return $urandom_range(0, n - 1) == 0;
    endfunction

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic logic [1:0] bad_status();
        return 2'($urandom_range(1, 3));
    endfunction

    task automatic issue_request(logic [1:0] f, logic [1:0] st, logic [31:0] resp,
                                 logic [31:0] lba);
        int gap;
        gap = sender_burst ? 0 : gap_length();
        @(negedge clk);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid         <= 1'b1;
        req.func          <= f;
        req.cmd_status    <= st;
        req.response_word <= resp;
        req.block_address <= lba;
        do @(posedge clk); while (!req.ready);
        sent++;
    endtask

    task automatic complete(logic [1:0] st, logic [31:0] resp);
        issue_request(FUNC_DONE, st, resp, $urandom);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        req.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [TRIES_W-1:0] val);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(posedge clk); while (!cfg.ready);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic set_limits(logic [TRIES_W-1:0] max_tries, logic [BUS_W-1:0] bus);
        wait_idle();
        write_reg(CFG_OP_COND_MAX_TRIES, max_tries);
        write_reg(CFG_BUS_WIDTH_CODE, {8'b0, bus});
        tries_limit = max_tries;
        settings++;
    endtask

    task automatic directed_checks();
        issue_request(FUNC_READ, CST_OK, 32'h0, 32'h0);          // request before bring-up
        complete(CST_OK, 32'h0);                                  // completion with nothing open
        issue_request(FUNC_START, CST_OK, 32'h0, 32'h0);
        complete(CST_TIMEOUT, 32'hFFFF_FFFF);                     // CMD0 fails
        issue_request(FUNC_START, CST_DATA_IO, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        complete(CST_OK, 32'h0);
        complete(CST_OK, 32'h0000_01AB);                          // wrong CMD8 echo
        issue_request(FUNC_START, CST_OK, 32'h0, 32'h0);
        complete(CST_OK, 32'h0);
        complete(CST_OK, 32'hFFFF_F1AA);                          // good echo, upper bits set
        complete(CST_OK, 32'h0);                                  // CMD55
        complete(CST_OK, 32'h7FFF_FFFF);                          // ACMD41 still busy
        complete(CST_DATA_IO, 32'h0);                             // CMD55 fails, retried
        complete(CST_OK, 32'h0);
        complete(CST_OK, 32'hC000_0000);                          // ready, high capacity
        complete(CST_OK, 32'h0);                                  // CMD2
        complete(CST_OK, 32'hFFFF_0000);                          // CMD3 with widest RCA
        complete(CST_PROTOCOL, 32'h0);                            // CMD9 outcome is ignored
        complete(CST_OK, 32'h0);                                  // CMD7
        complete(CST_OK, 32'h0);                                  // CMD55
        complete(CST_OK, 32'h0);                                  // ACMD6
        issue_request(FUNC_WRITE, CST_OK, 32'h0, 32'hFFFF_FFFF);
        issue_request(FUNC_READ, CST_OK, 32'h0, 32'h0);           // transfer still open
        complete(CST_DATA_IO, 32'h0);
    endtask

    task automatic bring_up();
        int planned;
        int misses;
        logic [31:0] word;
        issue_request(FUNC_START, 2'($urandom), $urandom, $urandom);
        if (chance(12))
        begin
            complete(bad_status(), $urandom);
            return;
        end
        complete(CST_OK, $urandom);
        word = $urandom;
        if (chance(12))
        begin
            if (chance(2))
                complete(bad_status(), word);
            else
            begin
                if (word[11:0] == CMD8_CHECK_PATTERN)
                    word[0] = ~word[0];
                complete(CST_OK, word);
            end
            return;
        end
        word[11:0] = CMD8_CHECK_PATTERN;
        complete(CST_OK, word);

        // Sometimes run the retry loop up to its limit, capped at 40 misses.
        planned = chance(6) ? ((tries_limit > 40) ? 40 : int'(tries_limit))
                            : $urandom_range(0, 2);
        misses = 0;
        while (misses < planned)
        begin
            if (chance(2))
                complete(bad_status(), $urandom);
            else
            begin
                complete(CST_OK, $urandom);
                word = $urandom;
                if (chance(2))
                    complete(bad_status(), word);
                else
                begin
                    word[OCR_BUSY_BIT] = 1'b0;
                    complete(CST_OK, word);
                end
            end
            misses++;
            if (misses >= tries_limit)
                return;
        end
        complete(CST_OK, $urandom);
        word = $urandom;
        word[OCR_BUSY_BIT] = 1'b1;
        complete(CST_OK, word);

        if (chance(20))
        begin
            complete(bad_status(), $urandom);
            return;
        end
        complete(CST_OK, $urandom);
        if (chance(20))
        begin
            complete(bad_status(), $urandom);
            return;
        end
        complete(CST_OK, $urandom);
        complete(2'($urandom), $urandom);
        if (chance(20))
        begin
            complete(bad_status(), $urandom);
            return;
        end
        complete(CST_OK, $urandom);
        if (chance(20))
        begin
            complete(bad_status(), $urandom);
            return;
        end
        complete(CST_OK, $urandom);
        if (chance(20))
        begin
            complete(bad_status(), $urandom);
            return;
        end
        complete(CST_OK, $urandom);
        bring_ups++;
        card_up = 1'b1;
    endtask

    task automatic run_transfers();
        int n;
        logic [1:0] f;
        n = $urandom_range(1, 6);
        repeat (n)
        begin
            f = chance(2) ? FUNC_READ : FUNC_WRITE;
            issue_request(f, 2'($urandom), $urandom, $urandom);
            transfers++;
            if (chance(8))
                issue_request(chance(2) ? FUNC_READ : FUNC_WRITE, 2'($urandom), $urandom,
                              $urandom);
            complete(chance(4) ? 2'($urandom) : CST_OK, $urandom);
            if (chance(8))
                complete(2'($urandom), $urandom);
        end
    endtask

    task automatic episode();
        sender_burst = chance(8);
        card_up = 1'b0;
        bring_up();
        if (card_up)
            run_transfers();
        if (chance(4))
            repeat ($urandom_range(1, 4))
                issue_request(2'($urandom), 2'($urandom), $urandom, $urandom);
        // Now and then let the block drain completely before going on.
        if (chance(40))
            wait_idle();
    endtask

    task automatic random_phase(logic [TRIES_W-1:0] max_tries, logic [BUS_W-1:0] bus);
        int target;
        set_limits(max_tries, bus);
        target = sent + 300;
        while (sent < target)
            episode();
    endtask

    initial
    begin : result_drain
        int cycle;
        int hold;
        int burst_left;
        cycle = 0;
        hold = 0;
        burst_left = 0;
        res.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            cycle++;
            // A long hold-off lets the input register and the result register both fill.
            if (cycle % 2000 == 700)
                hold = 80;
            else if (hold == 0 && burst_left == 0)
            begin
                if (chance(300))
                    burst_left = 120;
                else
                    hold = gap_length();
            end
            if (hold > 0)
            begin
                res.ready <= 1'b0;
                hold--;
            end
            else
            begin
                res.ready <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
            end
        end
    end

    initial
    begin : stimulus
        req.valid         = 1'b0;
        req.func          = FUNC_START;
        req.cmd_status    = CST_OK;
        req.response_word = '0;
        req.block_address = '0;
        cfg.valid         = 1'b0;
        cfg.index         = CFG_OP_COND_MAX_TRIES;
        cfg.data          = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        directed_checks();
        random_phase(10'd3, 2'd0);
        random_phase(10'd1, 2'd3);
        random_phase(10'd1023, 2'd1);
        random_phase(10'd0, 2'd2);
        random_phase(10'd2, 2'd1);

        wait_idle();
        repeat (4) @(negedge clk);
        $display("Covered %0d requests under %0d register settings; %0d results compared.",
                 sent, settings, compared);
        $display("Completed %0d bring-ups and issued %0d block transfers.", bring_ups, transfers);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("Timed out with %0d results still outstanding.", pending);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
